[src/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit scoped allocator: field widths,
// operation and status codes, controller states and controller commands.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Default sizing of the tables and of the address space.
  localparam int FREE_SLOTS_DEF   = 64;
  localparam int LIST_SLOTS_DEF   = 64;
  localparam int ADDRESS_BITS_DEF = 16;

  // Field widths of the words on the channels.
  localparam int OP_W       = 3;
  localparam int HANDLE_W   = 8;
  localparam int COUNT_W    = 17;
  localparam int STATUS_W   = 3;
  localparam int BASE_W     = 16;
  localparam int FREED_W    = 7;
  localparam int SCOPE_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENTER = 3'd3;
  localparam logic [OP_W-1:0] OP_LEAVE = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSEG    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSUF    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREEFULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_LISTFULL = 3'd6;
  localparam logic [STATUS_W-1:0] ST_INITED   = 3'd7;

  // Register selects (byte address bit 2).
  localparam logic REG_TOTAL_NODES   = 1'b0;
  localparam logic REG_FREE_DISABLED = 1'b1;

  // Reset values.
  localparam logic [COUNT_W-1:0] TOTAL_NODES_RST = 17'd4096;
  localparam logic [SCOPE_W-1:0] SCOPE_RST       = 8'd1;
  localparam logic [SCOPE_W-1:0] SCOPE_MAX       = 8'd255;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_CHK,
    S_A_SHRD,
    S_A_SHWR,
    S_F_RD,
    S_F_CHK,
    S_F_SHRD,
    S_F_SHWR,
    S_L_RD,
    S_L_CHK,
    S_DONE
  } ffsa_state_t;

  // Datapath commands.
  typedef enum logic [4:0] {
    C_NOP,
    C_LOAD,
    C_INIT,
    C_ENTER,
    C_SETST,
    C_FRD,
    C_FNEXT,
    C_ATAKE,
    C_FRDN,
    C_FSHW,
    C_FDEC,
    C_LRD,
    C_LNEXT,
    C_LHOLD,
    C_LRDN,
    C_LSHW,
    C_FREL,
    C_LRDTOP,
    C_LPOP,
    C_LEAVEEND,
    C_EMIT
  } ffsa_cmd_t;

  // Controller to datapath.
  typedef struct packed {
    ffsa_cmd_t           cmd;
    logic [STATUS_W-1:0] code;
  } ffsa_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            disabled;
    logic            fc_zero;
    logic            fc_full;
    logic            ec_zero;
    logic            ec_full;
    logic            fit;
    logic            exact;
    logic            f_last;
    logic            l_match;
    logic            l_last;
    logic            scope_hit;
    logic            out_free;
  } ffsa_stat_t;

endpackage

[src/ffsa_if.sv]
// ----------------------------------------------------------------------------
// ffsa_if
// Channel interfaces of the allocator: request words in, result words out.
// ----------------------------------------------------------------------------
interface ffsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [ffsa_pkg::OP_W-1:0]      operation;
  logic [ffsa_pkg::HANDLE_W-1:0]  list_id;
  logic [ffsa_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output operation, output list_id, output count,
                  input ready);
  modport sink   (input valid, input operation, input list_id, input count,
                  output ready);
endinterface

interface ffsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [ffsa_pkg::STATUS_W-1:0]  status;
  logic [ffsa_pkg::BASE_W-1:0]    base_address;
  logic [ffsa_pkg::FREED_W-1:0]   freed_count;

  modport source (output valid, output status, output base_address,
                  output freed_count, input ready);
  modport sink   (input valid, input status, input base_address,
                  input freed_count, output ready);
endinterface

[src/ffsa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: walks each operation through its scan, shift
// and write steps and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffsa_pkg::ffsa_stat_t stat,
  output ffsa_pkg::ffsa_ctl_t  ctl
);

  ffsa_pkg::ffsa_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffsa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ffsa_pkg::S_DISPATCH;
      end
      ffsa_pkg::S_DISPATCH: begin
        case (stat.op)
          ffsa_pkg::OP_ALLOC:
            state_nxt = stat.fc_zero ? ffsa_pkg::S_DONE : ffsa_pkg::S_A_RD;
          ffsa_pkg::OP_FREE:
            state_nxt = (stat.disabled || stat.fc_full || stat.ec_zero) ?
                        ffsa_pkg::S_DONE : ffsa_pkg::S_F_RD;
          ffsa_pkg::OP_LEAVE:
            state_nxt = stat.disabled ? ffsa_pkg::S_DONE : ffsa_pkg::S_L_RD;
          default:
            state_nxt = ffsa_pkg::S_DONE;
        endcase
      end
      ffsa_pkg::S_A_RD: state_nxt = ffsa_pkg::S_A_CHK;
      ffsa_pkg::S_A_CHK: begin
        if (stat.fit) begin
          if (stat.ec_full || !stat.exact) state_nxt = ffsa_pkg::S_DONE;
          else                             state_nxt = ffsa_pkg::S_A_SHRD;
        end else begin
          state_nxt = stat.f_last ? ffsa_pkg::S_DONE : ffsa_pkg::S_A_RD;
        end
      end
      ffsa_pkg::S_A_SHRD:
        state_nxt = stat.f_last ? ffsa_pkg::S_DONE : ffsa_pkg::S_A_SHWR;
      ffsa_pkg::S_A_SHWR: state_nxt = ffsa_pkg::S_A_SHRD;
      ffsa_pkg::S_F_RD:   state_nxt = ffsa_pkg::S_F_CHK;
      ffsa_pkg::S_F_CHK: begin
        if (stat.l_match)     state_nxt = ffsa_pkg::S_F_SHRD;
        else if (stat.l_last) state_nxt = ffsa_pkg::S_DONE;
        else                  state_nxt = ffsa_pkg::S_F_RD;
      end
      ffsa_pkg::S_F_SHRD:
        state_nxt = stat.l_last ? ffsa_pkg::S_DONE : ffsa_pkg::S_F_SHWR;
      ffsa_pkg::S_F_SHWR: state_nxt = ffsa_pkg::S_F_SHRD;
      ffsa_pkg::S_L_RD:
        state_nxt = stat.ec_zero ? ffsa_pkg::S_DONE : ffsa_pkg::S_L_CHK;
      ffsa_pkg::S_L_CHK:
        state_nxt = (stat.scope_hit && !stat.fc_full) ?
                    ffsa_pkg::S_L_RD : ffsa_pkg::S_DONE;
      ffsa_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = ffsa_pkg::S_IDLE;
      end
      default: state_nxt = ffsa_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    in_ready = 1'b0;
    ctl.cmd  = ffsa_pkg::C_NOP;
    ctl.code = ffsa_pkg::ST_OK;
    unique case (state_r)
      ffsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.cmd = ffsa_pkg::C_LOAD;
      end
      ffsa_pkg::S_DISPATCH: begin
        case (stat.op)
          ffsa_pkg::OP_INIT:  ctl.cmd = ffsa_pkg::C_INIT;
          ffsa_pkg::OP_ENTER: ctl.cmd = ffsa_pkg::C_ENTER;
          ffsa_pkg::OP_ALLOC: begin
            if (stat.fc_zero) begin
              ctl.cmd  = ffsa_pkg::C_SETST;
              ctl.code = ffsa_pkg::ST_NOSEG;
            end
          end
          ffsa_pkg::OP_FREE: begin
            ctl.cmd = ffsa_pkg::C_SETST;
            if (stat.disabled)     ctl.code = ffsa_pkg::ST_DISABLED;
            else if (stat.fc_full) ctl.code = ffsa_pkg::ST_FREEFULL;
            else if (stat.ec_zero) ctl.code = ffsa_pkg::ST_NOTFOUND;
            else                   ctl.cmd  = ffsa_pkg::C_NOP;
          end
          ffsa_pkg::OP_LEAVE: begin
            if (stat.disabled) begin
              ctl.cmd  = ffsa_pkg::C_SETST;
              ctl.code = ffsa_pkg::ST_DISABLED;
            end
          end
          default: ctl.cmd = ffsa_pkg::C_NOP;
        endcase
      end
      ffsa_pkg::S_A_RD: ctl.cmd = ffsa_pkg::C_FRD;
      ffsa_pkg::S_A_CHK: begin
        if (stat.fit) begin
          if (stat.ec_full) begin
            ctl.cmd  = ffsa_pkg::C_SETST;
            ctl.code = ffsa_pkg::ST_LISTFULL;
          end else begin
            ctl.cmd = ffsa_pkg::C_ATAKE;
          end
        end else if (stat.f_last) begin
          ctl.cmd  = ffsa_pkg::C_SETST;
          ctl.code = ffsa_pkg::ST_INSUF;
        end else begin
          ctl.cmd = ffsa_pkg::C_FNEXT;
        end
      end
      ffsa_pkg::S_A_SHRD:
        ctl.cmd = stat.f_last ? ffsa_pkg::C_FDEC : ffsa_pkg::C_FRDN;
      ffsa_pkg::S_A_SHWR: ctl.cmd = ffsa_pkg::C_FSHW;
      ffsa_pkg::S_F_RD:   ctl.cmd = ffsa_pkg::C_LRD;
      ffsa_pkg::S_F_CHK: begin
        if (stat.l_match) begin
          ctl.cmd = ffsa_pkg::C_LHOLD;
        end else if (stat.l_last) begin
          ctl.cmd  = ffsa_pkg::C_SETST;
          ctl.code = ffsa_pkg::ST_NOTFOUND;
        end else begin
          ctl.cmd = ffsa_pkg::C_LNEXT;
        end
      end
      ffsa_pkg::S_F_SHRD:
        ctl.cmd = stat.l_last ? ffsa_pkg::C_FREL : ffsa_pkg::C_LRDN;
      ffsa_pkg::S_F_SHWR: ctl.cmd = ffsa_pkg::C_LSHW;
      ffsa_pkg::S_L_RD:
        ctl.cmd = stat.ec_zero ? ffsa_pkg::C_LEAVEEND : ffsa_pkg::C_LRDTOP;
      ffsa_pkg::S_L_CHK: begin
        if (!stat.scope_hit) begin
          ctl.cmd = ffsa_pkg::C_LEAVEEND;
        end else if (stat.fc_full) begin
          ctl.cmd  = ffsa_pkg::C_SETST;
          ctl.code = ffsa_pkg::ST_FREEFULL;
        end else begin
          ctl.cmd = ffsa_pkg::C_LPOP;
        end
      end
      ffsa_pkg::S_DONE: begin
        if (stat.out_free) ctl.cmd = ffsa_pkg::C_EMIT;
      end
      default: ctl.cmd = ffsa_pkg::C_NOP;
    endcase
  end

endmodule

[src/ffsa_dp.sv]
// ----------------------------------------------------------------------------
// ffsa_dp
// Datapath of the allocator: the free-segment and list memories, the table
// counts, the scope depth, the scan indexes and the result register.
// ----------------------------------------------------------------------------
module ffsa_dp #(
  parameter int FREE_SLOTS   = ffsa_pkg::FREE_SLOTS_DEF,
  parameter int LIST_SLOTS   = ffsa_pkg::LIST_SLOTS_DEF,
  parameter int ADDRESS_BITS = ffsa_pkg::ADDRESS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffsa_pkg::ffsa_ctl_t             ctl,
  output ffsa_pkg::ffsa_stat_t            stat,
  input  logic [ffsa_pkg::OP_W-1:0]       in_operation,
  input  logic [ffsa_pkg::HANDLE_W-1:0]   in_list_id,
  input  logic [ffsa_pkg::COUNT_W-1:0]    in_count,
  input  logic [ffsa_pkg::COUNT_W-1:0]    total_nodes,
  input  logic                            free_disabled,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ffsa_pkg::STATUS_W-1:0]   out_status,
  output logic [ffsa_pkg::BASE_W-1:0]     out_base_address,
  output logic [ffsa_pkg::FREED_W-1:0]    out_freed_count
);

  localparam int FI = $clog2(FREE_SLOTS);
  localparam int FC = $clog2(FREE_SLOTS + 1);
  localparam int LI = $clog2(LIST_SLOTS);
  localparam int LC = $clog2(LIST_SLOTS + 1);
  localparam int AB = ADDRESS_BITS;
  localparam int CW = ffsa_pkg::COUNT_W;
  localparam int HW = ffsa_pkg::HANDLE_W;
  localparam int SW = ffsa_pkg::SCOPE_W;
  localparam logic [32:0] CAP = 33'(1) << AB;

  // Memories.
  logic [AB-1:0] fbase_mem   [FREE_SLOTS];
  logic [CW-1:0] fsize_mem   [FREE_SLOTS];
  logic [HW-1:0] lhandle_mem [LIST_SLOTS];
  logic [AB-1:0] lbase_mem   [LIST_SLOTS];
  logic [CW-1:0] llen_mem    [LIST_SLOTS];
  logic [SW-1:0] lscope_mem  [LIST_SLOTS];

  // Control state.
  logic [FC-1:0] fc_r;
  logic [LC-1:0] ec_r;
  logic [SW-1:0] scope_r;
  logic          out_valid_r;

  // Working registers.
  logic [ffsa_pkg::OP_W-1:0]     op_r;
  logic [HW-1:0]                 handle_r;
  logic [CW-1:0]                 cnt_r;
  logic [FI-1:0]                 fidx_r;
  logic [LI-1:0]                 lidx_r;
  logic [AB-1:0]                 hold_base_r;
  logic [CW-1:0]                 hold_len_r;
  logic [ffsa_pkg::STATUS_W-1:0] status_r;
  logic [AB-1:0]                 base_r;
  logic [ffsa_pkg::FREED_W-1:0]  freed_r;
  logic [ffsa_pkg::STATUS_W-1:0] out_status_r;
  logic [ffsa_pkg::BASE_W-1:0]   out_base_r;
  logic [ffsa_pkg::FREED_W-1:0]  out_freed_r;

  // Registered read data.
  logic [AB-1:0] f_rbase_r;
  logic [CW-1:0] f_rsize_r;
  logic [HW-1:0] l_rhandle_r;
  logic [AB-1:0] l_rbase_r;
  logic [CW-1:0] l_rlen_r;
  logic [SW-1:0] l_rscope_r;

  // Addresses and write ports.
  logic [FC-1:0] fc_m1;
  logic [LC-1:0] ec_m1;
  logic [FI-1:0] f_ra, f_wa;
  logic [LI-1:0] l_ra, l_wa;
  logic          f_we, l_we;
  logic [AB-1:0] f_wbase, l_wbase;
  logic [CW-1:0] f_wsize, l_wlen;
  logic [HW-1:0] l_whandle;
  logic [SW-1:0] l_wscope;
  logic [CW-1:0] init_size;

  assign fc_m1 = fc_r - FC'(1);
  assign ec_m1 = ec_r - LC'(1);

  // The initial segment is limited to the address space.
  assign init_size = ({16'b0, total_nodes} > CAP) ? CAP[CW-1:0] : total_nodes;

  // Read address selection.
  always_comb begin
    f_ra = (ctl.cmd == ffsa_pkg::C_FRDN) ? fidx_r + FI'(1) : fidx_r;
    case (ctl.cmd)
      ffsa_pkg::C_LRDN:   l_ra = lidx_r + LI'(1);
      ffsa_pkg::C_LRDTOP: l_ra = ec_m1[LI-1:0];
      default:            l_ra = lidx_r;
    endcase
  end

  // Free table write port.
  always_comb begin
    f_we    = 1'b0;
    f_wa    = fidx_r;
    f_wbase = f_rbase_r;
    f_wsize = f_rsize_r;
    case (ctl.cmd)
      ffsa_pkg::C_INIT: begin
        f_we    = (fc_r == '0);
        f_wa    = '0;
        f_wbase = '0;
        f_wsize = init_size;
      end
      ffsa_pkg::C_ATAKE: begin
        f_we    = (f_rsize_r > cnt_r);
        f_wbase = f_rbase_r + AB'(cnt_r);
        f_wsize = f_rsize_r - cnt_r;
      end
      ffsa_pkg::C_FSHW: f_we = 1'b1;
      ffsa_pkg::C_FREL: begin
        f_we    = 1'b1;
        f_wa    = fc_r[FI-1:0];
        f_wbase = hold_base_r;
        f_wsize = hold_len_r;
      end
      ffsa_pkg::C_LPOP: begin
        f_we    = 1'b1;
        f_wa    = fc_r[FI-1:0];
        f_wbase = l_rbase_r;
        f_wsize = l_rlen_r;
      end
      default: f_we = 1'b0;
    endcase
  end

  // List table write port.
  always_comb begin
    l_we      = 1'b0;
    l_wa      = lidx_r;
    l_whandle = l_rhandle_r;
    l_wbase   = l_rbase_r;
    l_wlen    = l_rlen_r;
    l_wscope  = l_rscope_r;
    case (ctl.cmd)
      ffsa_pkg::C_ATAKE: begin
        l_we      = 1'b1;
        l_wa      = ec_r[LI-1:0];
        l_whandle = handle_r;
        l_wbase   = f_rbase_r;
        l_wlen    = cnt_r;
        l_wscope  = scope_r;
      end
      ffsa_pkg::C_LSHW: l_we = 1'b1;
      default:          l_we = 1'b0;
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (f_we) begin
      fbase_mem[f_wa] <= f_wbase;
      fsize_mem[f_wa] <= f_wsize;
    end
    f_rbase_r <= fbase_mem[f_ra];
    f_rsize_r <= fsize_mem[f_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lhandle_mem[l_wa] <= l_whandle;
      lbase_mem[l_wa]   <= l_wbase;
      llen_mem[l_wa]    <= l_wlen;
      lscope_mem[l_wa]  <= l_wscope;
    end
    l_rhandle_r <= lhandle_mem[l_ra];
    l_rbase_r   <= lbase_mem[l_ra];
    l_rlen_r    <= llen_mem[l_ra];
    l_rscope_r  <= lscope_mem[l_ra];
  end

  // Table counts, scope depth and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      ec_r        <= '0;
      scope_r     <= ffsa_pkg::SCOPE_RST;
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.cmd)
        ffsa_pkg::C_INIT: begin
          if (fc_r == '0) begin
            fc_r    <= FC'(1);
            ec_r    <= '0;
            scope_r <= ffsa_pkg::SCOPE_RST;
          end
        end
        ffsa_pkg::C_ENTER: begin
          if (scope_r != ffsa_pkg::SCOPE_MAX) scope_r <= scope_r + SW'(1);
        end
        ffsa_pkg::C_ATAKE: ec_r <= ec_r + LC'(1);
        ffsa_pkg::C_FDEC:  fc_r <= fc_m1;
        ffsa_pkg::C_FREL, ffsa_pkg::C_LPOP: begin
          fc_r <= fc_r + FC'(1);
          ec_r <= ec_m1;
        end
        ffsa_pkg::C_LEAVEEND: begin
          if (scope_r != '0) scope_r <= scope_r - SW'(1);
        end
        default: ;
      endcase
      if (ctl.cmd == ffsa_pkg::C_EMIT) out_valid_r <= 1'b1;
      else if (out_ready)              out_valid_r <= 1'b0;
    end
  end

  // Item, index and result registers.
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      ffsa_pkg::C_LOAD: begin
        op_r     <= in_operation;
        handle_r <= in_list_id;
        cnt_r    <= in_count;
        fidx_r   <= '0;
        lidx_r   <= '0;
        status_r <= ffsa_pkg::ST_OK;
        base_r   <= '0;
        freed_r  <= '0;
      end
      ffsa_pkg::C_INIT: begin
        if (fc_r != '0) status_r <= ffsa_pkg::ST_INITED;
      end
      ffsa_pkg::C_SETST: status_r <= ctl.code;
      ffsa_pkg::C_FNEXT, ffsa_pkg::C_FSHW: fidx_r <= fidx_r + FI'(1);
      ffsa_pkg::C_ATAKE: base_r <= f_rbase_r;
      ffsa_pkg::C_LNEXT, ffsa_pkg::C_LSHW: lidx_r <= lidx_r + LI'(1);
      ffsa_pkg::C_LHOLD: begin
        hold_base_r <= l_rbase_r;
        hold_len_r  <= l_rlen_r;
      end
      ffsa_pkg::C_LPOP: freed_r <= freed_r + ffsa_pkg::FREED_W'(1);
      ffsa_pkg::C_EMIT: begin
        out_status_r <= status_r;
        out_base_r   <= ffsa_pkg::BASE_W'(base_r);
        out_freed_r  <= freed_r;
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.op        = op_r;
    stat.disabled  = free_disabled;
    stat.fc_zero   = (fc_r == '0);
    stat.fc_full   = (fc_r == FC'(FREE_SLOTS));
    stat.ec_zero   = (ec_r == '0);
    stat.ec_full   = (ec_r == LC'(LIST_SLOTS));
    stat.fit       = (f_rsize_r >= cnt_r);
    stat.exact     = !(f_rsize_r > cnt_r);
    stat.f_last    = (FC'(fidx_r) == fc_m1);
    stat.l_match   = (l_rhandle_r == handle_r);
    stat.l_last    = (LC'(lidx_r) == ec_m1);
    stat.scope_hit = (l_rscope_r == scope_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_base_address = out_base_r;
  assign out_freed_count  = out_freed_r;

endmodule

[src/first_fit_scoped_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_scoped_allocator
// Top level: configuration registers, request and result channels, and the
// sequencer and datapath of the allocator.
// ----------------------------------------------------------------------------
// One request word is handled at a time and gives one result word. Init,
// enter scope, unknown codes and refused requests go from dispatch
// straight to the result. Allocate scans the free table one segment at a
// time, and when a segment is used up exactly it closes the gap by moving
// each later segment down. Free scans the list table one list at a time
// and closes the gap by moving each later list down. Leave scope releases
// the lists of the current scope one at a time. Each table memory has a
// single read and write port, so scans and shifts go one entry at a time.
// A finished result sits in an output register; the next request is
// accepted while it waits.
module first_fit_scoped_allocator #(
  parameter int FREE_SLOTS   = ffsa_pkg::FREE_SLOTS_DEF,
  parameter int LIST_SLOTS   = ffsa_pkg::LIST_SLOTS_DEF,
  parameter int ADDRESS_BITS = ffsa_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ffsa_in_if.sink                             in_ch,
  ffsa_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffsa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ffsa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ffsa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [ffsa_pkg::COUNT_W-1:0] total_nodes_r;
  logic                         free_disabled_r;
  logic                         cfg_wr;
  ffsa_pkg::ffsa_ctl_t          ctl;
  ffsa_pkg::ffsa_stat_t         stat;

  // Configuration writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_nodes_r   <= ffsa_pkg::TOTAL_NODES_RST;
      free_disabled_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == ffsa_pkg::REG_TOTAL_NODES) begin
        total_nodes_r <= pwdata[ffsa_pkg::COUNT_W-1:0];
      end else begin
        free_disabled_r <= pwdata[0];
      end
    end
  end

  // Register readback.
  always_comb begin
    if (paddr[2] == ffsa_pkg::REG_FREE_DISABLED) begin
      prdata = ffsa_pkg::CFG_DATA_W'(free_disabled_r);
    end else begin
      prdata = ffsa_pkg::CFG_DATA_W'(total_nodes_r);
    end
  end

  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ffsa_dp #(
    .FREE_SLOTS   (FREE_SLOTS),
    .LIST_SLOTS   (LIST_SLOTS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_operation     (in_ch.operation),
    .in_list_id       (in_ch.list_id),
    .in_count         (in_ch.count),
    .total_nodes      (total_nodes_r),
    .free_disabled    (free_disabled_r),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_base_address (out_ch.base_address),
    .out_freed_count  (out_ch.freed_count)
  );

  // The free table is never empty and full at once.
  a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.fc_full && stat.fc_zero))
    else $error("free count out of range");

  // Only one request word is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while busy");

  // Released lists are reported only with a success or a full free table.
  a_freed_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.freed_count != '0) |->
      (out_ch.status == ffsa_pkg::ST_OK) || (out_ch.status == ffsa_pkg::ST_FREEFULL))
    else $error("freed count with wrong status");

endmodule
